@@ rtl/core/assert_macros.svh @@
// Assertion macros for the RTL files of the job sorter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Plain property, checked at every edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

@@ rtl/core/rojs_pkg.sv @@
// Types and constants shared by the job sorter modules.
package rojs_pkg;

    localparam int MAX_JOBS   = 1024;
    localparam int VALUE_BITS = 16;
    localparam int FIELD_BITS = 16;
    localparam int ARR_W      = 11;
    localparam int POS_W      = $clog2(MAX_JOBS);
    localparam int CNT_W      = $clog2(MAX_JOBS + 1);
    localparam int PROD_W     = 2 * VALUE_BITS;

    localparam logic [ARR_W-1:0] ARR_FIRST = ARR_W'(1);
    localparam logic [ARR_W-1:0] ARR_LAST  = {ARR_W{1'b1}};

    // request function codes
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_PUSH_OK   = 2'd0;
    localparam logic [1:0] STAT_POP_OK    = 2'd1;
    localparam logic [1:0] STAT_POP_EMPTY = 2'd2;
    localparam logic [1:0] STAT_PUSH_FULL = 2'd3;

    typedef struct packed {
        logic                  func;
        logic [FIELD_BITS-1:0] job_time;
        logic [FIELD_BITS-1:0] job_fine;
    } cmd_t;

    typedef struct packed {
        logic [ARR_W-1:0] job_number;
        logic             batch_end;
        logic [1:0]       status;
    } res_t;

    // one stored job
    typedef struct packed {
        logic [VALUE_BITS-1:0] dur;
        logic [VALUE_BITS-1:0] fine;
        logic [ARR_W-1:0]      arrival;
    } entry_t;

    // best-so-far candidate travelling toward cell 0
    typedef struct packed {
        logic             valid;
        entry_t           entry;
        logic [POS_W-1:0] pos;
    } wave_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic take_prev;   // push: shift toward the tail
        logic take_next;   // removal: close the gap
        logic start;       // this cell holds the oldest job, seed the scan
    } cell_ctl_t;

endpackage

@@ rtl/core/rojs_cell.sv @@
// One cell of the job chain: a stored job plus one stage of the min-ratio scan.
module rojs_cell
    import rojs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [POS_W-1:0] cell_index,
    input  cell_ctl_t        ctl,
    input  entry_t           prev_entry,
    input  entry_t           next_entry,
    input  wave_t            wave_in,
    output entry_t           entry,
    output wave_t            wave
);

    entry_t           entry_reg, entry_next;
    logic             wave_valid_reg, wave_valid_next;
    entry_t           wave_entry_reg, wave_entry_next;
    logic [POS_W-1:0] wave_pos_reg, wave_pos_next;
    logic [PROD_W-1:0] own_cross, in_cross;
    logic             own_first;

    // cross products: own job goes first when own.t * best.f < best.t * own.f
    assign own_cross = PROD_W'(entry_reg.dur) * PROD_W'(wave_in.entry.fine);
    assign in_cross  = PROD_W'(wave_in.entry.dur) * PROD_W'(entry_reg.fine);
    assign own_first = own_cross < in_cross;

    // stored job: shift on push, close the gap on removal
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.take_prev)
        begin
            entry_next = prev_entry;
        end
        else if (ctl.take_next)
        begin
            entry_next = next_entry;
        end
    end

    // scan stage: older candidates arrive from the next cell
    always_comb
    begin
        wave_valid_next = 1'b0;
        wave_entry_next = wave_in.entry;
        wave_pos_next   = wave_in.pos;
        if (ctl.start)
        begin
            wave_valid_next = 1'b1;
            wave_entry_next = entry_reg;
            wave_pos_next   = cell_index;
        end
        else if (wave_in.valid)
        begin
            wave_valid_next = 1'b1;
            if (own_first)
            begin
                wave_entry_next = entry_reg;
                wave_pos_next   = cell_index;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_valid_reg <= 1'b0;
        end
        else
        begin
            wave_valid_reg <= wave_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg      <= entry_next;
        wave_entry_reg <= wave_entry_next;
        wave_pos_reg   <= wave_pos_next;
    end

    assign entry = entry_reg;
    assign wave  = '{valid: wave_valid_reg, entry: wave_entry_reg, pos: wave_pos_reg};

endmodule

@@ rtl/core/ratio_ordered_job_sorter.sv @@
// Top level of the job sorter: cell chain, sequencer and result register.
//
// Jobs are kept in a chain of MAX_JOBS cells, newest in cell 0 and oldest at the
// highest occupied cell. A push or any refused request (pop on empty, push when
// full) loads its result directly. On a pop the best-ratio candidate is seeded at
// the oldest job and moves one cell per cycle toward cell 0, each cell comparing
// its job by cross-multiplication, so the scan covers every stored job; the gap
// is then closed in a single shift. Each request yields exactly one result, held
// in an output register. A new request is taken only while no scan runs and that
// register is empty or its result is taken in the same cycle, so a stalled result
// holds off the input. The job store needs no clearing after reset.
`include "assert_macros.svh"

module ratio_ordered_job_sorter
    import rojs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [ARR_W-1:0] arrival_reg, arrival_next;
    logic             res_valid_reg, res_valid_next;
    res_t             res_reg, res_next;
    logic             res_load;

    logic             cmd_fire, is_pop, full, empty, push_ok, pop_go, done;
    logic [CNT_W-1:0] count_dec;
    logic [POS_W-1:0] count_m1;
    entry_t           new_entry;
    wave_t            best;

    entry_t    entry_q [MAX_JOBS];
    wave_t     wave_q  [MAX_JOBS];
    cell_ctl_t ctl     [MAX_JOBS];

    // request decode
    assign cmd_ready = (state_reg == ST_IDLE) && (!res_valid_reg || res_ready);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign is_pop    = cmd.func == FUNC_POP;
    assign full      = count_reg == CNT_W'(MAX_JOBS);
    assign empty     = count_reg == '0;
    assign push_ok   = cmd_fire && !is_pop && !full;
    assign pop_go    = cmd_fire && is_pop && !empty;
    assign count_dec = count_reg - CNT_W'(1);
    assign count_m1  = count_dec[POS_W-1:0];
    assign best      = wave_q[0];
    assign done      = best.valid;

    assign new_entry = '{dur: cmd.job_time[VALUE_BITS-1:0],
                         fine: cmd.job_fine[VALUE_BITS-1:0],
                         arrival: arrival_reg};

    // cell chain
    for (genvar gi = 0; gi < MAX_JOBS; gi++)
    begin : g_cell
        entry_t prev_e, next_e;
        wave_t  wave_from;

        assign ctl[gi].take_prev = push_ok;
        assign ctl[gi].take_next = done && (best.pos <= POS_W'(gi));
        assign ctl[gi].start     = pop_go && (count_m1 == POS_W'(gi));

        if (gi == 0)
        begin : g_head
            assign prev_e = new_entry;
        end
        else
        begin : g_body
            assign prev_e = entry_q[gi-1];
        end

        if (gi == MAX_JOBS - 1)
        begin : g_tail
            assign next_e    = '0;
            assign wave_from = '0;
        end
        else
        begin : g_link
            assign next_e    = entry_q[gi+1];
            assign wave_from = wave_q[gi+1];
        end

        rojs_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (POS_W'(gi)),
            .ctl        (ctl[gi]),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .wave_in    (wave_from),
            .entry      (entry_q[gi]),
            .wave       (wave_q[gi])
        );
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        arrival_next = arrival_reg;
        res_load     = 1'b0;
        res_next     = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (is_pop)
                    begin
                        if (empty)
                        begin
                            res_load = 1'b1;
                            res_next = '{job_number: '0, batch_end: 1'b0,
                                         status: STAT_POP_EMPTY};
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else if (full)
                    begin
                        res_load = 1'b1;
                        res_next = '{job_number: '0, batch_end: 1'b0,
                                     status: STAT_PUSH_FULL};
                    end
                    else
                    begin
                        count_next   = count_reg + CNT_W'(1);
                        arrival_next = (arrival_reg == ARR_LAST) ? ARR_FIRST
                                                                 : arrival_reg + ARR_W'(1);
                        res_load     = 1'b1;
                        res_next     = '{job_number: '0, batch_end: 1'b0,
                                         status: STAT_PUSH_OK};
                    end
                end
            end
            ST_SCAN:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                    count_next = count_dec;
                    res_load   = 1'b1;
                    res_next   = '{job_number: best.entry.arrival,
                                   batch_end: (count_dec == '0),
                                   status: STAT_POP_OK};
                    if (count_dec == '0)
                    begin
                        arrival_next = ARR_FIRST;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register
    assign res_valid_next = res_load ? 1'b1 : (res_ready ? 1'b0 : res_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            arrival_reg   <= ARR_FIRST;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            arrival_reg   <= arrival_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // checks
    `ASSERT_IMPL(a_done_in_scan, clk, rst_n, done, state_reg == ST_SCAN,
        "scan result outside a pop")
    `ASSERT_IMPL(a_best_in_range, clk, rst_n, done, CNT_W'(best.pos) < count_reg,
        "best job beyond fill level")
    `ASSERT_NEXT(a_push_count, clk, rst_n, push_ok,
        count_reg == $past(count_reg) + CNT_W'(1), "push did not grow the store")
    `ASSERT_NEXT(a_res_source, clk, rst_n, !res_valid_reg && !res_load, !res_valid_reg,
        "result appeared without a source")

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the ratio ordered job sorter.
`timescale 1ns / 1ps

module testbench;
    import rojs_pkg::*;

    // one job as the checker keeps it, in push order
    typedef struct {
        logic [VALUE_BITS-1:0] dur;
        logic [VALUE_BITS-1:0] fine;
        logic [ARR_W-1:0]      arrival;
    } held_job_t;

    // one row of the directed stimulus; known rows carry a typed-in outcome
    typedef struct packed {
        logic                  func;
        logic [FIELD_BITS-1:0] job_time;
        logic [FIELD_BITS-1:0] job_fine;
        logic                  known;
        logic [ARR_W-1:0]      want_number;
        logic                  want_end;
        logic [1:0]            want_status;
    } directed_row_t;

    localparam int MIX_REQUESTS  = 470;
    localparam int DRAIN_CYCLES  = 1100;

    logic clk = 1'b0;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic res_valid;
    logic res_ready = 1'b0;
    res_t res;

    // checker state: stored jobs, next arrival number, outcomes still owed
    held_job_t        held_jobs[$];
    logic [ARR_W-1:0] next_ticket = ARR_FIRST;
    res_t             expected_outcomes[$];

    int  mismatch_count = 0;
    int  requests_sent = 0;
    bit  send_burst = 1'b0;
    bit  recv_burst = 1'b0;
    int  recv_stall_left = 0;

    // directed requests: extremes, zero time and fine, empty pops, ties
    directed_row_t directed_rows [0:23] = '{
        '{FUNC_POP,  16'd0,     16'd0,     1'b1, 11'd0, 1'b0, STAT_POP_EMPTY},
        '{FUNC_PUSH, 16'hFFFF,  16'hFFFF,  1'b1, 11'd0, 1'b0, STAT_PUSH_OK},
        '{FUNC_PUSH, 16'd1,     16'd1,     1'b1, 11'd0, 1'b0, STAT_PUSH_OK},
        '{FUNC_PUSH, 16'd1,     16'hFFFF,  1'b1, 11'd0, 1'b0, STAT_PUSH_OK},
        '{FUNC_PUSH, 16'hFFFF,  16'd1,     1'b1, 11'd0, 1'b0, STAT_PUSH_OK},
        '{FUNC_PUSH, 16'd0,     16'd5,     1'b1, 11'd0, 1'b0, STAT_PUSH_OK},
        '{FUNC_PUSH, 16'd7,     16'd0,     1'b1, 11'd0, 1'b0, STAT_PUSH_OK},
        '{FUNC_PUSH, 16'd0,     16'd0,     1'b1, 11'd0, 1'b0, STAT_PUSH_OK},
        '{FUNC_POP,  16'd0,     16'd0,     1'b0, 11'd0, 1'b0, STAT_POP_OK},
        '{FUNC_POP,  16'hFFFF,  16'hFFFF,  1'b0, 11'd0, 1'b0, STAT_POP_OK},
        '{FUNC_POP,  16'd0,     16'd0,     1'b0, 11'd0, 1'b0, STAT_POP_OK},
        '{FUNC_POP,  16'hFFFF,  16'hFFFF,  1'b0, 11'd0, 1'b0, STAT_POP_OK},
        '{FUNC_POP,  16'd0,     16'd0,     1'b0, 11'd0, 1'b0, STAT_POP_OK},
        '{FUNC_POP,  16'hFFFF,  16'hFFFF,  1'b0, 11'd0, 1'b0, STAT_POP_OK},
        '{FUNC_POP,  16'd0,     16'd0,     1'b0, 11'd0, 1'b0, STAT_POP_OK},
        '{FUNC_POP,  16'd0,     16'd0,     1'b1, 11'd0, 1'b0, STAT_POP_EMPTY},
        '{FUNC_PUSH, 16'd3,     16'd3,     1'b1, 11'd0, 1'b0, STAT_PUSH_OK},
        '{FUNC_POP,  16'd0,     16'd0,     1'b1, 11'd1, 1'b1, STAT_POP_OK},
        '{FUNC_PUSH, 16'd2,     16'd4,     1'b1, 11'd0, 1'b0, STAT_PUSH_OK},
        '{FUNC_PUSH, 16'd1,     16'd2,     1'b1, 11'd0, 1'b0, STAT_PUSH_OK},
        '{FUNC_PUSH, 16'd3,     16'd6,     1'b1, 11'd0, 1'b0, STAT_PUSH_OK},
        '{FUNC_POP,  16'd0,     16'd0,     1'b1, 11'd1, 1'b0, STAT_POP_OK},
        '{FUNC_POP,  16'd0,     16'd0,     1'b1, 11'd2, 1'b0, STAT_POP_OK},
        '{FUNC_POP,  16'd0,     16'd0,     1'b1, 11'd3, 1'b1, STAT_POP_OK}
    };

    ratio_ordered_job_sorter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always #10 clk = ~clk;

    // ratio order: apply one request to the held jobs, return its outcome
    function automatic res_t ratio_order_apply(cmd_t req);
        res_t      outcome;
        held_job_t job;
        int        best;
        int        idx;
        bit [63:0] lhs;
        bit [63:0] rhs;
        outcome = '0;
        if (req.func == FUNC_PUSH)
        begin
            if (held_jobs.size() >= MAX_JOBS)
            begin
                outcome.status = STAT_PUSH_FULL;
            end
            else
            begin
                job.dur     = req.job_time[VALUE_BITS-1:0];
                job.fine    = req.job_fine[VALUE_BITS-1:0];
                job.arrival = next_ticket;
                held_jobs.insert(held_jobs.size(), job);
                // the arrival number skips zero when it wraps
                next_ticket = (next_ticket == ARR_LAST) ? ARR_FIRST : next_ticket + 1'b1;
                outcome.status = STAT_PUSH_OK;
            end
        end
        else if (held_jobs.size() == 0)
        begin
            outcome.status = STAT_POP_EMPTY;
        end
        else
        begin
            // strict win only, so equal ratios stay with the older job
            best = 0;
            for (idx = 1; idx < held_jobs.size(); idx++)
            begin
                lhs = 64'(held_jobs[idx].dur) * 64'(held_jobs[best].fine);
                rhs = 64'(held_jobs[best].dur) * 64'(held_jobs[idx].fine);
                if (lhs < rhs)
                    best = idx;
            end
            outcome.job_number = held_jobs[best].arrival;
            outcome.status     = STAT_POP_OK;
            held_jobs.delete(best);
            if (held_jobs.size() == 0)
            begin
                outcome.batch_end = 1'b1;
                next_ticket       = ARR_FIRST;
            end
        end
        return outcome;
    endfunction

    // sender idle length: bursts with no gaps, else mostly short, few long
    function automatic int sender_gap();
        int roll;
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        if (send_burst)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 25);
    endfunction

    // field value: extremes, zero now and then, small values for ties, bits
    function automatic logic [FIELD_BITS-1:0] job_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return '0;
        else if (roll < 10)
            return FIELD_BITS'(1);
        else if (roll < 17)
            return '1;
        else if (roll < 45)
            return FIELD_BITS'($urandom_range(1, 6));
        else if (roll < 60)
            return FIELD_BITS'(1) << $urandom_range(0, FIELD_BITS - 1);
        else
            return FIELD_BITS'($urandom);
    endfunction

    // predict, then hold the request on the bus until it is taken
    task automatic send_request(input cmd_t req, input logic known, input res_t want);
        res_t predicted;
        int   gap;
        predicted = ratio_order_apply(req);
        expected_outcomes.insert(expected_outcomes.size(), known ? want : predicted);
        requests_sent++;
        gap = sender_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= req;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic pop_job();
        cmd_t req;
        req.func     = FUNC_POP;
        req.job_time = FIELD_BITS'($urandom);
        req.job_fine = FIELD_BITS'($urandom);
        send_request(req, 1'b0, '0);
    endtask

    // random job; a quarter share one of a few base ratios to force ties
    task automatic push_random_job();
        cmd_t req;
        int   scale;
        req.func = FUNC_PUSH;
        if ($urandom_range(0, 3) == 0)
        begin
            scale        = $urandom_range(1, 2000);
            req.job_time = FIELD_BITS'($urandom_range(1, 5) * scale);
            req.job_fine = FIELD_BITS'($urandom_range(1, 5) * scale);
        end
        else
        begin
            req.job_time = job_value();
            req.job_fine = job_value();
        end
        send_request(req, 1'b0, '0);
    endtask

    // result side ready: stalls of random length, with stall-free stretches
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else if (recv_stall_left > 0)
        begin
            recv_stall_left--;
            res_ready <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 49) == 0)
                recv_burst = !recv_burst;
            if (recv_burst || $urandom_range(0, 99) < 60)
                res_ready <= 1'b1;
            else
            begin
                recv_stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40)
                                                              : $urandom_range(0, 2);
                res_ready <= 1'b0;
            end
        end
    end

    // compare each taken result with the oldest outstanding outcome
    always @(posedge clk)
    begin : outcome_check
        res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_outcomes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: number %0d end %0b status %0d",
                             res.job_number, res.batch_end, res.status);
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (res.job_number !== want.job_number || res.batch_end !== want.batch_end
                    || res.status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected number %0d end %0b status %0d, got %0d %0b %0d",
                                 want.job_number, want.batch_end, want.status,
                                 res.job_number, res.batch_end, res.status);
                end
            end
        end
    end

    initial
    begin : stimulus
        cmd_t req;
        res_t want;
        int   row_idx;
        int   mix_start;
        int   pushes_left;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table
        for (row_idx = 0; row_idx < $size(directed_rows); row_idx++)
        begin
            req.func         = directed_rows[row_idx].func;
            req.job_time     = directed_rows[row_idx].job_time;
            req.job_fine     = directed_rows[row_idx].job_fine;
            want.job_number  = directed_rows[row_idx].want_number;
            want.batch_end   = directed_rows[row_idx].want_end;
            want.status      = directed_rows[row_idx].want_status;
            send_request(req, directed_rows[row_idx].known, want);
        end

        // random batches, each pushed and drained to the end, stray empty pops
        mix_start = requests_sent;
        while (requests_sent - mix_start < MIX_REQUESTS)
        begin
            if ($urandom_range(0, 9) == 0)
                pop_job();
            pushes_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 10);
            while (pushes_left > 0 || held_jobs.size() > 0)
            begin
                if (pushes_left > 0 && (held_jobs.size() == 0 || $urandom_range(0, 99) < 60))
                begin
                    push_random_job();
                    pushes_left--;
                end
                else
                    pop_job();
            end
        end

        // fill the store, push into it while full, pop a few at full depth
        while (held_jobs.size() < MAX_JOBS)
            push_random_job();
        repeat (3) push_random_job();
        repeat (4) pop_job();
        while (held_jobs.size() < MAX_JOBS)
            push_random_job();
        repeat (2) push_random_job();
        repeat (3) pop_job();
        cmd_valid <= 1'b0;

        // drain, then give a full-depth scan time to show any stray result
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // hang guard
    initial
    begin
        #200_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
